### rtl/sdr_pkg.sv
// package for the sample dump receiver
// transaction types, codes and byte constants shared by all rtl files
package sdr_pkg;

  localparam int unsigned ChanW  = 7;
  localparam int unsigned PosW   = 7;
  localparam int unsigned IdxW   = 3;

  localparam logic [7:0] ByteSox    = 8'hf0;
  localparam logic [7:0] ByteNonRt  = 8'h7e;
  localparam logic [7:0] ByteHdrTyp = 8'h01;
  localparam logic [7:0] BytePktTyp = 8'h02;
  localparam logic [7:0] ByteAck    = 8'h7f;
  localparam logic [7:0] ByteEox    = 8'hf7;

  localparam logic [PosW-1:0] HdrLastPos = PosW'(20);
  localparam logic [PosW-1:0] PktCsumPos = PosW'(125);
  localparam logic [PosW-1:0] PktLastPos = PosW'(126);
  localparam logic [PosW-1:0] HdrLeadN   = PosW'(4);
  localparam logic [PosW-1:0] PktLeadN   = PosW'(5);
  localparam logic [IdxW-1:0] AckLastIdx = IdxW'(6);

  typedef enum logic [1:0] {
    KIND_STORE  = 2'd0,
    KIND_TX     = 2'd1,
    KIND_STATUS = 2'd2
  } sdr_kind_e;

  typedef enum logic [2:0] {
    EV_NONE      = 3'd0,
    EV_HDR_DONE  = 3'd1,
    EV_PKT_DONE  = 3'd2,
    EV_HDR_ERR   = 3'd3,
    EV_DUMP_DONE = 3'd4
  } sdr_event_e;

  typedef enum logic [1:0] {
    MODE_STORE,
    MODE_STATUS,
    MODE_ACK
  } sdr_mode_e;

  typedef struct packed {
    logic       action;
    logic [7:0] rx_byte;
  } sdr_in_t;

  typedef struct packed {
    logic [1:0]       kind;
    logic [7:0]       data;
    logic [2:0]       event_res;
    logic             checksum_ok;
    logic [ChanW-1:0] packet_number;
    logic             last;
  } sdr_out_t;

  typedef struct packed {
    sdr_mode_e        mode;
    logic [7:0]       rx_byte;
    sdr_event_e       event_res;
    logic             checksum_ok;
    logic [ChanW-1:0] packet_number;
    logic [ChanW-1:0] channel;
  } sdr_desc_t;

endpackage

### rtl/sample_dump_receiver.sv
// top level of the sample dump receiver
// joins sdr_framer and sdr_emitter; uses sdr_pkg
//
// channel  | handshake                 | payload
// in       | in_valid_i / in_ready_o   | in_data_i (sdr_in_t)
// out      | out_valid_o / out_ready_i | out_data_o (sdr_out_t)
// cfg      | cfg_we_i                  | cfg_wdata_i (channel)
//
// an input transaction is decoded as it is taken into a descriptor register
// the emitter then delivers one result per cycle while out_ready_i is high
// from its output register; a completed header or packet yields seven
// results and holds its descriptor until all are loaded; any other input
// yields one or none; input is taken again as its last result is loaded
// reset clears control state at once, not data registers; no startup sweep
module sample_dump_receiver
  import sdr_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [ChanW-1:0] cfg_wdata_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  sdr_in_t          in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output sdr_out_t         out_data_o
);

  logic      desc_valid;
  logic      pop;
  sdr_desc_t desc;
  logic      step;

  assign in_ready_o = !desc_valid || pop;
  assign step       = in_valid_i && in_ready_o;

  sdr_framer u_framer (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .step_i       (step),
    .in_i         (in_data_i),
    .pop_i        (pop),
    .desc_valid_o (desc_valid),
    .desc_o       (desc)
  );

  sdr_emitter u_emitter (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .desc_valid_i (desc_valid),
    .desc_i       (desc),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_data_o   (out_data_o)
  );

endmodule

### rtl/sdr_framer.sv
// frame tracking and checksum state for the sample dump receiver
// turns each input transaction into at most one result descriptor; uses sdr_pkg
module sdr_framer
  import sdr_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [ChanW-1:0] cfg_wdata_i,
  input  logic             step_i,
  input  sdr_in_t          in_i,
  input  logic             pop_i,
  output logic             desc_valid_o,
  output sdr_desc_t        desc_o
);

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_PACKET,
    PH_STOP
  } phase_e;

  phase_e           phase_q, phase_d;
  logic [PosW-1:0]  pos_q, pos_d;
  logic [6:0]       run_q, run_d;
  logic [7:0]       recv_q, recv_d;
  logic [ChanW-1:0] count_q, count_d;
  logic [ChanW-1:0] chan_q;
  logic             desc_valid_q;
  sdr_desc_t        desc_q;

  logic             has_res;
  sdr_mode_e        mode;
  sdr_event_e       ev;
  logic             ok;
  logic [7:0]       lead_exp;
  logic [7:0]       c;

  assign c = in_i.rx_byte;

  always_comb begin
    case (pos_q)
      PosW'(0): lead_exp = ByteSox;
      PosW'(1): lead_exp = ByteNonRt;
      PosW'(2): lead_exp = {1'b0, chan_q};
      PosW'(3): lead_exp = (phase_q == PH_HEADER) ? ByteHdrTyp : BytePktTyp;
      default:  lead_exp = {1'b0, count_q};
    endcase
  end

  always_comb begin
    phase_d = phase_q;
    pos_d   = pos_q;
    run_d   = run_q;
    recv_d  = recv_q;
    count_d = count_q;
    has_res = 1'b0;
    mode    = MODE_STORE;
    ev      = EV_NONE;
    ok      = 1'b0;
    if (step_i) begin
      unique case (phase_q)
        PH_HEADER: begin
          if (!in_i.action) begin
            if (pos_q < HdrLeadN) begin
              if (c == lead_exp) begin
                has_res = 1'b1;
                pos_d   = pos_q + PosW'(1);
              end
            end else if (pos_q >= HdrLastPos) begin
              has_res = 1'b1;
              if (c == ByteEox) begin
                mode    = MODE_ACK;
                ev      = EV_HDR_DONE;
                phase_d = PH_PACKET;
                pos_d   = '0;
                run_d   = '0;
              end else begin
                mode    = MODE_STATUS;
                ev      = EV_HDR_ERR;
                phase_d = PH_STOP;
              end
            end else begin
              has_res = 1'b1;
              pos_d   = pos_q + PosW'(1);
            end
          end
        end
        PH_PACKET: begin
          if (in_i.action) begin
            has_res = 1'b1;
            mode    = MODE_STATUS;
            ev      = EV_DUMP_DONE;
            phase_d = PH_STOP;
          end else if (pos_q < PktLeadN) begin
            if (c == lead_exp) begin
              has_res = 1'b1;
              pos_d   = pos_q + PosW'(1);
              if (pos_q != '0) begin
                run_d = run_q ^ c[6:0];
              end
            end
          end else if (pos_q == PktCsumPos) begin
            has_res = 1'b1;
            recv_d  = c;
            pos_d   = pos_q + PosW'(1);
          end else if (pos_q >= PktLastPos) begin
            if (c == ByteEox) begin
              has_res = 1'b1;
              mode    = MODE_ACK;
              ev      = EV_PKT_DONE;
              ok      = ({1'b0, run_q} == recv_q);
              count_d = count_q + ChanW'(1);
              pos_d   = '0;
              run_d   = '0;
            end
          end else begin
            has_res = 1'b1;
            run_d   = run_q ^ c[6:0];
            pos_d   = pos_q + PosW'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_HEADER;
      pos_q        <= '0;
      run_q        <= '0;
      recv_q       <= '0;
      count_q      <= '0;
      chan_q       <= '0;
      desc_valid_q <= 1'b0;
    end else begin
      phase_q <= phase_d;
      pos_q   <= pos_d;
      run_q   <= run_d;
      recv_q  <= recv_d;
      count_q <= count_d;
      if (cfg_we_i) begin
        chan_q <= cfg_wdata_i;
      end
      if (has_res) begin
        desc_valid_q <= 1'b1;
      end else if (pop_i) begin
        desc_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (has_res) begin
      desc_q.mode          <= mode;
      desc_q.rx_byte       <= c;
      desc_q.event_res     <= ev;
      desc_q.checksum_ok   <= ok;
      desc_q.packet_number <= count_q;
      desc_q.channel       <= chan_q;
    end
  end

  assign desc_valid_o = desc_valid_q;
  assign desc_o       = desc_q;

endmodule

### rtl/sdr_emitter.sv
// result sequencer for the sample dump receiver
// walks one descriptor into up to seven result transactions; uses sdr_pkg
module sdr_emitter
  import sdr_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      desc_valid_i,
  input  sdr_desc_t desc_i,
  output logic      pop_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output sdr_out_t  out_data_o
);

  logic [IdxW-1:0] idx_q;
  logic            out_valid_q;
  sdr_out_t        out_q;
  sdr_out_t        item;
  logic            load;
  logic            item_last;

  assign load      = desc_valid_i && (!out_valid_q || out_ready_i);
  assign item_last = (desc_i.mode != MODE_ACK) || (idx_q == AckLastIdx);
  assign pop_o     = load && item_last;

  always_comb begin
    item.event_res     = desc_i.event_res;
    item.checksum_ok   = desc_i.checksum_ok;
    item.packet_number = desc_i.packet_number;
    item.last          = item_last;
    item.kind          = KIND_TX;
    case (idx_q)
      IdxW'(0): begin
        if (desc_i.mode == MODE_STATUS) begin
          item.kind = KIND_STATUS;
          item.data = '0;
        end else begin
          item.kind = KIND_STORE;
          item.data = desc_i.rx_byte;
        end
      end
      IdxW'(1): item.data = ByteSox;
      IdxW'(2): item.data = ByteNonRt;
      IdxW'(3): item.data = {1'b0, desc_i.channel};
      IdxW'(4): item.data = ByteAck;
      IdxW'(5): item.data = {1'b0, desc_i.packet_number};
      default:  item.data = ByteEox;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (load) begin
        out_valid_q <= 1'b1;
        idx_q       <= item_last ? '0 : idx_q + IdxW'(1);
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q <= item;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

### rtl/sdr_checker.sv
// port level checks for the sample dump receiver
// bound to sample_dump_receiver; uses sdr_pkg
module sdr_port_checks
  import sdr_pkg::*;
(
  input logic     clk_i,
  input logic     rst_ni,
  input logic     out_valid_o,
  input logic     out_ready_i,
  input sdr_out_t out_data_o
);

  // a stalled result holds
  a_out_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  // a result that is not last is followed at once by an ack byte of the same transaction
  a_burst_cont : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !out_data_o.last |=>
      out_valid_o && out_data_o.kind == KIND_TX &&
      out_data_o.event_res == $past(out_data_o.event_res) &&
      out_data_o.packet_number == $past(out_data_o.packet_number))
    else $error("ack burst broken");

  // status results stand alone
  a_status_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.kind == KIND_STATUS |->
      out_data_o.last && out_data_o.data == 8'h00)
    else $error("status result not alone");

  // the header is always acked with packet zero
  a_hdr_pkt0 : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.event_res == EV_HDR_DONE |->
      out_data_o.packet_number == '0)
    else $error("header done with nonzero packet number");

endmodule

bind sample_dump_receiver sdr_port_checks u_sdr_port_checks (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);
